// ===== rtl/ampq_pkg.sv =====
// Shared types, field widths and operation codes for the bounded max-priority queue.
// No dependencies; every other file in this folder imports it.
package ampq_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int VALUE_W   = 32;
   localparam int PRI_W     = 16;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 7;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [PRI_W-1:0]   prio;
   } entry_type;

   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } ctrl_type;

endpackage

// ===== rtl/ampq_cell.sv =====
// One storage cell of the queue chain: holds one entry and one stage of the
// running maximum that travels along the chain. Depends on ampq_pkg.
module ampq_cell #(
   parameter int  DEPTH = ampq_pkg::DEPTH_DEF,
   parameter int  INDEX = 0,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  ampq_pkg::ctrl_type  ctrl,
   input  logic [CNT_W-1:0]    count,
   input  logic [IDX_W-1:0]    sel_idx,
   input  ampq_pkg::entry_type nbr_entry,
   output ampq_pkg::entry_type entry,
   input  logic                cand_in_valid,
   input  ampq_pkg::entry_type cand_in_entry,
   input  logic [IDX_W-1:0]    cand_in_idx,
   output logic                cand_out_valid,
   output ampq_pkg::entry_type cand_out_entry,
   output logic [IDX_W-1:0]    cand_out_idx
);
   import ampq_pkg::*;

   localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(INDEX);
   localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(INDEX);

   entry_type        entry_ff, entry_in;
   logic             cand_valid_ff, cand_valid_in;
   entry_type        cand_entry_ff, cand_entry_in;
   logic [IDX_W-1:0] cand_idx_ff, cand_idx_in;
   logic             own_valid;
   logic             own_wins;

   assign own_valid = POS_CNT < count;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq && (count == POS_CNT)) begin
         entry_in = ctrl.item;
      end else if (ctrl.deq && (POS_IDX >= sel_idx)) begin
         entry_in = nbr_entry;
      end
   end

   // The older candidate keeps its place on a full tie.
   always_comb begin
      own_wins = own_valid && (!cand_in_valid
         || (entry_ff.prio > cand_in_entry.prio)
         || ((entry_ff.prio == cand_in_entry.prio)
             && ($signed(entry_ff.value) > $signed(cand_in_entry.value))));
      cand_valid_in = cand_in_valid || own_valid;
      cand_entry_in = own_wins ? entry_ff : cand_in_entry;
      cand_idx_in   = own_wins ? POS_IDX : cand_in_idx;
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      cand_entry_ff <= cand_entry_in;
      cand_idx_ff   <= cand_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
      end
   end

   assign entry          = entry_ff;
   assign cand_out_valid = cand_valid_ff;
   assign cand_out_entry = cand_entry_ff;
   assign cand_out_idx   = cand_idx_ff;

endmodule

// ===== rtl/array_max_priority_queue.sv =====
// Bounded max-priority queue built as a chain of storage cells, with its sequencer.
// Depends on ampq_pkg and ampq_cell.
//
// A transaction is taken when start is high and busy is low, and its result is
// shown for exactly one cycle with rsp_valid high, once the request has moved the
// state register to execute and go has been registered into rsp_valid; the
// receiver cannot hold results off. Entries sit in arrival order, one per cell,
// and the best entry is found by a comparison wave that moves one cell per cycle
// down the chain of DEPTH cells. Enqueue and the unused mode do not wait for the
// wave. Peek and dequeue on a non-empty queue wait until the settle counter,
// reloaded by each successful enqueue or dequeue, has run down to zero, so that
// the wave has settled. There is no clearing pass after reset.
module array_max_priority_queue #(
   parameter int DEPTH = ampq_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ampq_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [ampq_pkg::VALUE_W-1:0]   req_item_value,
   input  logic [ampq_pkg::PRI_W-1:0]            req_item_priority,
   output logic                                  rsp_valid,
   output logic [ampq_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [ampq_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic [ampq_pkg::PRI_W-1:0]            rsp_out_priority,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   output logic [ampq_pkg::OCC_W-1:0]            rsp_occupancy
);
   import ampq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   entry_type          item_ff, item_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   settle_ff, settle_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   entry_type          out_ff, out_in;
   logic               empty_ff, empty_in;
   logic               full_ff, full_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   ctrl_type           ctrl;
   logic               accept;
   logic               is_select;
   logic               go;
   logic               enq_ok;
   logic               deq_ok;

   entry_type          entries    [DEPTH];
   logic               cand_valid [DEPTH+1];
   entry_type          cand_entry [DEPTH+1];
   logic [IDX_W-1:0]   cand_idx   [DEPTH+1];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign is_select = (mode_ff == MODE_DEQUEUE) || (mode_ff == MODE_PEEK);
   assign go        = (state_ff == ST_EXEC) && (!is_select || (count_ff == '0)
                      || (settle_ff == '0));
   assign enq_ok    = go && (mode_ff == MODE_ENQUEUE) && (count_ff != FULL_CNT);
   assign deq_ok    = go && (mode_ff == MODE_DEQUEUE) && (count_ff != '0);

   assign ctrl.enq  = enq_ok;
   assign ctrl.deq  = deq_ok;
   assign ctrl.item = item_ff;

   assign cand_valid[0] = 1'b0;
   assign cand_entry[0] = '0;
   assign cand_idx[0]   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type nbr;
      if (i == DEPTH - 1) begin : g_last
         assign nbr = entries[i];
      end else begin : g_mid
         assign nbr = entries[i+1];
      end
      ampq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .count          (count_ff),
         .sel_idx        (cand_idx[DEPTH]),
         .nbr_entry      (nbr),
         .entry          (entries[i]),
         .cand_in_valid  (cand_valid[i]),
         .cand_in_entry  (cand_entry[i]),
         .cand_in_idx    (cand_idx[i]),
         .cand_out_valid (cand_valid[i+1]),
         .cand_out_entry (cand_entry[i+1]),
         .cand_out_idx   (cand_idx[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      item_in  = item_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in            = ST_EXEC;
               mode_in             = req_mode;
               item_in.value       = req_item_value;
               item_in.prio        = req_item_priority;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + ONE_CNT;
      end else if (deq_ok) begin
         count_in = count_ff - ONE_CNT;
      end
      settle_in = settle_ff;
      if (enq_ok || deq_ok) begin
         settle_in = FULL_CNT;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - ONE_CNT;
      end
   end

   always_comb begin
      rsp_valid_in = go;
      status_in    = STATUS_OK;
      out_in       = '0;
      case (mode_ff)
         MODE_ENQUEUE: begin
            if (count_ff == FULL_CNT) begin
               status_in = STATUS_FULL;
            end
         end
         MODE_DEQUEUE, MODE_PEEK: begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               out_in = cand_entry[DEPTH];
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
      empty_in = (count_in == '0);
      full_in  = (count_in == FULL_CNT);
      occ_in   = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      item_ff <= item_in;
      if (go) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_value    = out_ff.value;
   assign rsp_out_priority = out_ff.prio;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// ===== sim/tb_array_max_priority_queue.sv =====
// Self-checking testbench for the bounded max-priority queue: directed and random
// enqueue, dequeue and peek transactions checked against a behavioural predictor.
// Depends on ampq_pkg and the array_max_priority_queue RTL.
module tb_array_max_priority_queue;
   import ampq_pkg::*;

   localparam int DEPTH        = DEPTH_DEF;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = DEPTH + 4;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_ITEMS = 560;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic [PRI_W-1:0]          PRIO_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value;
      logic [PRI_W-1:0]          prio;
      logic                      is_empty;
      logic                      is_full;
      logic [OCC_W-1:0]          occupancy;
   } queue_reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [MODE_W-1:0]         req_mode = MODE_UNUSED;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic [PRI_W-1:0]          req_item_priority = '0;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [PRI_W-1:0]          rsp_out_priority;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;
   logic [OCC_W-1:0]          rsp_occupancy;

   logic signed [VALUE_W-1:0] held_values [DEPTH];
   logic [PRI_W-1:0]          held_prios [DEPTH];
   int                        held_count = 0;

   queue_reply_type replies_due [$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;

   array_max_priority_queue #(.DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_item_value(req_item_value),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_value(rsp_out_value),
      .rsp_out_priority(rsp_out_priority),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .rsp_occupancy(rsp_occupancy)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_array_max_priority_queue: FAIL");
         $finish;
      end
   end

   // Applies one transaction to the modelled queue and returns the reply it should give.
   function automatic queue_reply_type apply_queue_op(input logic [MODE_W-1:0] mode,
                                                      input logic signed [VALUE_W-1:0] value,
                                                      input logic [PRI_W-1:0] prio);
      queue_reply_type reply;
      int              best;
      reply = '0;
      reply.status = STATUS_OK;
      case (mode)
         MODE_ENQUEUE: begin
            if (held_count >= DEPTH) begin
               reply.status = STATUS_FULL;
            end else begin
               held_values[held_count] = value;
               held_prios[held_count] = prio;
               held_count++;
            end
         end
         MODE_DEQUEUE, MODE_PEEK: begin
            if (held_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < held_count; i++) begin
                  if (held_prios[i] > held_prios[best] ||
                      (held_prios[i] == held_prios[best] && held_values[i] > held_values[best]))
                     best = i;
               end
               reply.value = held_values[best];
               reply.prio = held_prios[best];
               if (mode == MODE_DEQUEUE) begin
                  for (int i = best; i < held_count - 1; i++) begin
                     held_values[i] = held_values[i + 1];
                     held_prios[i] = held_prios[i + 1];
                  end
                  held_count--;
               end
            end
         end
         default: begin
         end
      endcase
      reply.is_empty = (held_count == 0);
      reply.is_full = (held_count == DEPTH);
      reply.occupancy = held_count[OCC_W-1:0];
      return reply;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 2) - 1;
         1: return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [PRI_W-1:0] pick_prio();
      case ($urandom_range(0, 3))
         0: return PRI_W'($urandom_range(0, 3));
         1: return $urandom_range(0, 1) ? PRIO_MAX : '0;
         default: return PRI_W'($urandom);
      endcase
   endfunction

   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, what);
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic signed [VALUE_W-1:0] value,
                            input logic [PRI_W-1:0] prio);
      pace();
      start <= 1'b1;
      req_mode <= mode;
      req_item_value <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (busy !== 1'b0);
      replies_due.push_back(apply_queue_op(mode, value, prio));
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   always @(posedge clock) begin : check_replies
      queue_reply_type want;
      queue_reply_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.status = rsp_status;
         got.value = rsp_out_value;
         got.prio = rsp_out_priority;
         got.is_empty = rsp_is_empty;
         got.is_full = rsp_is_full;
         got.occupancy = rsp_occupancy;
         if (replies_due.size() == 0) begin
            note_failure("Result transaction arrived with none outstanding.");
         end else begin
            want = replies_due.pop_front();
            if (got.status !== want.status || got.value !== want.value ||
                got.prio !== want.prio || got.is_empty !== want.is_empty ||
                got.is_full !== want.is_full || got.occupancy !== want.occupancy)
               note_failure($sformatf({"Mismatch: expected status %0d value %0d priority %0d",
                  " empty %0b full %0b occupancy %0d; got status %0d value %0d priority %0d",
                  " empty %0b full %0b occupancy %0d."},
                  want.status, want.value, want.prio, want.is_empty, want.is_full,
                  want.occupancy, got.status, got.value, got.prio, got.is_empty,
                  got.is_full, got.occupancy));
         end
      end
   end

   task automatic test_empty_queue();
      send_item(MODE_PEEK, VALUE_MAX, PRIO_MAX);
      send_item(MODE_DEQUEUE, VALUE_MIN, '0);
      send_item(MODE_UNUSED, pick_value(), pick_prio());
   endtask

   task automatic test_extremes_and_ties();
      send_item(MODE_ENQUEUE, VALUE_MIN, '0);
      send_item(MODE_ENQUEUE, VALUE_MAX, '0);
      send_item(MODE_PEEK, '0, '0);
      send_item(MODE_ENQUEUE, -1, PRIO_MAX);
      send_item(MODE_ENQUEUE, 5, PRIO_MAX);
      send_item(MODE_ENQUEUE, 5, PRIO_MAX);
      send_item(MODE_ENQUEUE, 0, 16'd1);
      send_item(MODE_PEEK, '0, '0);
      send_item(MODE_UNUSED, VALUE_MAX, PRIO_MAX);
      repeat (7) send_item(MODE_DEQUEUE, '0, '0);
      send_item(MODE_PEEK, '0, '0);
   endtask

   task automatic test_capacity();
      wait_for_replies();
      while (held_count < DEPTH)
         send_item(MODE_ENQUEUE, pick_value(), pick_prio());
      send_item(MODE_ENQUEUE, VALUE_MAX, PRIO_MAX);
      send_item(MODE_ENQUEUE, pick_value(), pick_prio());
      send_item(MODE_PEEK, '0, '0);
      send_item(MODE_UNUSED, '0, '0);
      while (held_count > 0)
         send_item($urandom_range(0, 3) == 0 ? MODE_PEEK : MODE_DEQUEUE, pick_value(), pick_prio());
      send_item(MODE_DEQUEUE, '0, '0);
   endtask

   task automatic test_random_mix();
      int sent;
      int phase_left;
      int enq_pct;
      int roll;
      logic [MODE_W-1:0] mode;
      sent = 0;
      phase_left = 0;
      enq_pct = 50;
      while (sent < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
               0: enq_pct = 85;
               1: enq_pct = 50;
               default: enq_pct = 15;
            endcase
            if ($urandom_range(0, 3) == 0)
               wait_for_replies();
         end
         roll = $urandom_range(0, 99);
         if (roll < 3)
            mode = MODE_UNUSED;
         else if (roll < enq_pct)
            mode = MODE_ENQUEUE;
         else
            mode = ($urandom_range(0, 2) == 0) ? MODE_PEEK : MODE_DEQUEUE;
         send_item(mode, pick_value(), pick_prio());
         phase_left--;
         sent++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_extremes_and_ties();
      test_capacity();
      test_random_mix();
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_array_max_priority_queue: PASS");
      else
         $display("tb_array_max_priority_queue: FAIL");
      $finish;
   end

endmodule
